// ===== hw/rtl/esbcd_pkg.sv =====
package esbcd_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] DAY_SECS  = 32'd86400;
  localparam logic [WORD_W-1:0] HOUR_SECS = 32'd3600;
  localparam logic [WORD_W-1:0] MIN_SECS  = 32'd60;
  localparam logic [WORD_W-1:0] WEEK_DAYS = 32'd7;
  localparam logic [WORD_W-1:0] EPOCH_WDAY = 32'd4;

  // Years are counted as an offset from 1970
  localparam logic [7:0] BASE_OFF      = 8'd30;   // 2000
  localparam logic [7:0] LAST_OFF      = 8'd129;  // 2099
  localparam logic [7:0] NO_LEAP_OFF   = 8'd130;  // 2100, a century that is not leap
  localparam logic [3:0] LAST_MONTH    = 4'd11;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic [7:0] year_off;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [8:0] yday;
  } core_res_t;

  // Covers 1970..2106: the only century in range besides 2000 is 2100
  function automatic logic is_leap_off(input logic [7:0] yoff);
    logic [7:0] y2;
    y2 = yoff + 8'd2;
    return (y2[1:0] == 2'b00) && (yoff != NO_LEAP_OFF);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Two decimal digits of a value below 100; v*205 >> 11 equals v/10 here
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

// ===== hw/rtl/esbcd_alu.sv =====
module esbcd_alu (
  input  logic [esbcd_pkg::WORD_W-1:0] a,
  input  logic [esbcd_pkg::WORD_W-1:0] b,
  output logic [esbcd_pkg::WORD_W-1:0] diff,
  output logic                         ge
);
  import esbcd_pkg::*;

  logic [WORD_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[WORD_W-1:0];
  assign ge   = ~full[WORD_W];

endmodule

// ===== hw/rtl/esbcd_core.sv =====
module esbcd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [esbcd_pkg::WORD_W-1:0] secs,
  input  logic                         take,
  output esbcd_pkg::core_stat_t        stat,
  output esbcd_pkg::core_res_t         res
);
  import esbcd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DAY  = 3'd1;
  localparam logic [2:0] ST_HOUR = 3'd2;
  localparam logic [2:0] ST_MIN  = 3'd3;
  localparam logic [2:0] ST_WDAY = 3'd4;
  localparam logic [2:0] ST_YEAR = 3'd5;
  localparam logic [2:0] ST_MON  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [15:0]       quo_r, quo_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [15:0]       days_r, days_nxt;
  logic [7:0]        year_r, year_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [4:0]        day_r, day_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        minute_r, minute_nxt;
  logic [5:0]        second_r, second_nxt;
  logic [2:0]        wday_r, wday_nxt;
  logic [8:0]        yday_r, yday_nxt;

  logic [WORD_W-1:0] b_op;
  logic [WORD_W-1:0] diff;
  logic              ge;
  logic              leap;

  assign leap = is_leap_off(year_r);

  always_comb begin
    case (state_r)
      ST_DAY:  b_op = DAY_SECS << k_r;
      ST_HOUR: b_op = HOUR_SECS << k_r;
      ST_MIN:  b_op = MIN_SECS << k_r;
      ST_WDAY: b_op = WEEK_DAYS << k_r;
      ST_YEAR: b_op = leap ? 32'd366 : 32'd365;
      ST_MON:  b_op = WORD_W'(month_len(mon_r, leap));
      default: b_op = '0;
    endcase
  end

  esbcd_alu u_alu (
    .a    (acc_r),
    .b    (b_op),
    .diff (diff),
    .ge   (ge)
  );

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    quo_nxt    = quo_r;
    k_nxt      = k_r;
    days_nxt   = days_r;
    year_nxt   = year_r;
    mon_nxt    = mon_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    wday_nxt   = wday_r;
    yday_nxt   = yday_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          acc_nxt   = secs;
          quo_nxt   = '0;
          k_nxt     = 4'd15;
          state_nxt = ST_DAY;
        end
      end
      ST_DAY, ST_HOUR, ST_MIN, ST_WDAY: begin
        // one restoring quotient bit per cycle
        if (ge) begin
          acc_nxt        = diff;
          quo_nxt[k_r]   = 1'b1;
        end
        if (k_r == 4'd0) begin
          quo_nxt = '0;
          case (state_r)
            ST_DAY: begin
              days_nxt  = quo_r | (ge ? 16'd1 : 16'd0);
              k_nxt     = 4'd4;
              state_nxt = ST_HOUR;
            end
            ST_HOUR: begin
              hour_nxt  = quo_r[4:0] | (ge ? 5'd1 : 5'd0);
              k_nxt     = 4'd5;
              state_nxt = ST_MIN;
            end
            ST_MIN: begin
              minute_nxt = quo_r[5:0] | (ge ? 6'd1 : 6'd0);
              second_nxt = ge ? diff[5:0] : acc_r[5:0];
              acc_nxt    = WORD_W'(days_r) + EPOCH_WDAY;
              k_nxt      = 4'd12;
              state_nxt  = ST_WDAY;
            end
            default: begin
              wday_nxt  = ge ? diff[2:0] : acc_r[2:0];
              acc_nxt   = WORD_W'(days_r);
              year_nxt  = '0;
              state_nxt = ST_YEAR;
            end
          endcase
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          acc_nxt  = diff;
          year_nxt = year_r + 8'd1;
        end else begin
          yday_nxt  = acc_r[8:0];
          mon_nxt   = '0;
          state_nxt = ST_MON;
        end
      end
      ST_MON: begin
        // December absorbs whatever is left
        if (ge && (mon_r != LAST_MONTH)) begin
          acc_nxt = diff;
          mon_nxt = mon_r + 4'd1;
        end else begin
          day_nxt   = acc_r[4:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    quo_r    <= quo_nxt;
    k_r      <= k_nxt;
    days_r   <= days_nxt;
    year_r   <= year_nxt;
    mon_r    <= mon_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    second_r <= second_nxt;
    wday_r   <= wday_nxt;
    yday_r   <= yday_nxt;
  end

  assign stat.idle    = (state_r == ST_IDLE);
  assign stat.done    = (state_r == ST_DONE);
  assign res.year_off = year_r;
  assign res.month    = mon_r;
  assign res.day      = day_r;
  assign res.hour     = hour_r;
  assign res.minute   = minute_r;
  assign res.second   = second_r;
  assign res.weekday  = wday_r;
  assign res.yday     = yday_r;

`ifndef SYNTHESIS
  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR) |-> (year_r <= 8'd136))
    else $error("year offset ran past 2106");
  a_mon_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MON) |-> (mon_r <= LAST_MONTH))
    else $error("month index ran past December");
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> ((day_r <= 5'd30) && (yday_r <= 9'd365) && (wday_r <= 3'd6)))
    else $error("finished result out of range");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (state_r == ST_IDLE)) |=> (state_r == ST_DAY))
    else $error("transfer accepted but conversion did not start");
`endif

endmodule

// ===== hw/rtl/epoch_seconds_to_bcd_datetime.sv =====
// Channel | Dir | Ports            | Content
// in_     | in  | tvalid/tready/   | tdata[31:0] epoch_seconds
//         |     | tdata            |
// out_    | out | tvalid/tready/   | tdata: year/month/day/hour/minute/second BCD,
//         |     | tdata/tuser      | weekday, day_of_year; tuser: out_of_range
//
// From the input transfer until the core is free again, a conversion runs
// 40 quotient-bit steps on the shared subtractor, then one year step per whole
// year since 1970 plus one, then one month step per whole month plus one.
// One item at a time; in_tready is high only while the core is idle.
// A finished result moves into the output register, so the next transfer is
// taken while it still waits; the core holds its result if that register is full.
// rst_n clears the sequencer and the output valid flag.
module epoch_seconds_to_bcd_datetime (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] year_bcd, [12:8] month_bcd, [18:13] day_bcd, [24:19] hour_bcd,
  // [31:25] minute_bcd, [38:32] second_bcd, [41:39] weekday,
  // [50:42] day_of_year, [55:51] zero
  output logic [55:0] out_tdata,
  output logic        out_tuser   // [0] out_of_range
);
  import esbcd_pkg::*;

  core_stat_t  stat;
  core_res_t   res;
  logic        start;
  logic        take;
  logic        flag;
  logic [7:0]  year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd;
  logic        out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r;
  logic        out_user_r;

  assign in_tready = stat.idle;
  assign start     = in_tvalid & stat.idle;
  assign take      = stat.done & (~out_valid_r | out_tready);

  esbcd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .secs  (in_tdata),
    .take  (take),
    .stat  (stat),
    .res   (res)
  );

  assign flag       = (res.year_off < BASE_OFF) || (res.year_off > LAST_OFF);
  assign year_bcd   = to_bcd(7'(res.year_off - BASE_OFF));
  assign month_bcd  = to_bcd(7'(res.month) + 7'd1);
  assign day_bcd    = to_bcd(7'(res.day) + 7'd1);
  assign hour_bcd   = to_bcd(7'(res.hour));
  assign minute_bcd = to_bcd(7'(res.minute));
  assign second_bcd = to_bcd(7'(res.second));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load on handoff; year, month and day fields drop to zero outside 2000..2099
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {5'b0,
                     res.yday,
                     res.weekday,
                     second_bcd[6:0],
                     minute_bcd[6:0],
                     hour_bcd[5:0],
                     flag ? 6'd0 : day_bcd[5:0],
                     flag ? 5'd0 : month_bcd[4:0],
                     flag ? 8'd0 : year_bcd};
      out_user_r <= flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned N_RANDOM  = 1530;
  localparam int unsigned HOLD_LEN  = 1500;
  localparam int unsigned DRAIN_CYC = 250;

  // Result word, most significant field first, so it maps onto out_tdata
  typedef struct packed {
    logic [4:0] pad;
    logic [8:0] day_of_year;
    logic [2:0] weekday;
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
  } datetime_t;

  typedef struct packed {
    logic      out_of_range;
    datetime_t dt;
  } stamp_t;

  localparam int unsigned MDAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;

  logic [31:0] epoch_q [$];
  stamp_t      calendar_q [$];
  int unsigned n_items   = 0;
  int unsigned sent_cnt  = 0;
  int unsigned err_cnt   = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  epoch_seconds_to_bcd_datetime u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [7:0] bcd2(input int unsigned v);
    return 8'((((v / 10) % 10) << 4) | (v % 10));
  endfunction

  function automatic stamp_t epoch_to_calendar(input logic [31:0] secs);
    stamp_t      r;
    int unsigned tod, days, year, ylen, mon, mlen;
    r    = '0;
    tod  = secs % 86400;
    days = secs / 86400;
    r.dt.hour_bcd   = 6'(bcd2(tod / 3600));
    r.dt.minute_bcd = 7'(bcd2((tod % 3600) / 60));
    r.dt.second_bcd = 7'(bcd2(tod % 60));
    r.dt.weekday    = 3'((days + 4) % 7);
    year = 1970;
    ylen = 365;
    forever begin
      ylen = leap_year(year) ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      year++;
    end
    r.dt.day_of_year = 9'(days);
    mon = 0;
    forever begin
      mlen = (mon == 1 && leap_year(year)) ? 29 : MDAYS[mon];
      if (days < mlen || mon == 11) break;
      days -= mlen;
      mon++;
    end
    r.out_of_range = (year < 2000) || (year > 2099);
    if (!r.out_of_range) begin
      r.dt.year_bcd  = bcd2(year - 2000);
      r.dt.month_bcd = 5'(bcd2(mon + 1));
      r.dt.day_bcd   = 6'(bcd2(days + 1));
    end
    return r;
  endfunction

  // Phases: sender idles 35% / receiver 62%, then swapped, then no idling
  function automatic int unsigned idle_pct(input bit sender);
    if (sent_cnt < n_items / 3) return sender ? 35 : 62;
    if (sent_cnt < 2 * n_items / 3) return sender ? 62 : 35;
    return 0;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // Driver: one transfer per handshake, random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        calendar_q.push_back(epoch_to_calendar(in_tdata));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (epoch_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= epoch_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, early in the no-idle phase
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt == 2 * n_items / 3 + 40) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (calendar_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual %h / %b", $time, out_tdata, out_tuser);
          err_cnt++;
        end else begin
          stamp_t    want;
          datetime_t got;
          want = calendar_q.pop_front();
          got  = datetime_t'(out_tdata);
          compare_field("year_bcd", want.dt.year_bcd, got.year_bcd);
          compare_field("month_bcd", want.dt.month_bcd, got.month_bcd);
          compare_field("day_bcd", want.dt.day_bcd, got.day_bcd);
          compare_field("hour_bcd", want.dt.hour_bcd, got.hour_bcd);
          compare_field("minute_bcd", want.dt.minute_bcd, got.minute_bcd);
          compare_field("second_bcd", want.dt.second_bcd, got.second_bcd);
          compare_field("weekday", want.dt.weekday, got.weekday);
          compare_field("day_of_year", want.dt.day_of_year, got.day_of_year);
          compare_field("pad", want.dt.pad, got.pad);
          compare_field("out_of_range", want.out_of_range, out_tuser);
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  initial begin
    logic [31:0] corner_secs [$];
    longint      t;
    int unsigned pick, y, days;
    corner_secs = '{
      32'd0,          32'd86399,      32'd86400,      32'd68169600,   // 1972-02-29
      32'd946684799,  32'd946684800,  32'd951782400,  32'd951868800,  // 2000 Feb 29, Mar 1
      32'd978220800,  32'd978307200,  32'd1735603200, 32'd1709164799,
      32'd4107542399, 32'd4107542400, 32'd4112553600, 32'd4112640000, // 2100, no Feb 29
      32'h7FFFFFFF,   32'h80000000,   32'hAAAAAAAA,   32'h55555555,
      32'hFFFFFFFE,   32'hFFFFFFFF
    };
    foreach (corner_secs[i]) epoch_q.push_back(corner_secs[i]);
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        t = $urandom;
      end else if (pick < 80) begin
        t = $urandom_range(32'd4107542399, 32'd946684800);
      end else if (pick < 90) begin
        // edges of a day
        t = longint'($urandom_range(49710, 0)) * 86400;
        if ($urandom_range(1)) t += 86399;
      end else begin
        // around a new year
        y = $urandom_range(2106, 1970);
        days = 0;
        for (int unsigned k = 1970; k < y; k++) days += leap_year(k) ? 366 : 365;
        t = longint'(days) * 86400 + $urandom_range(2) - 1;
        if (t < 0) t = 0;
      end
      if (t > 64'hFFFFFFFF) t = 64'hFFFFFFFF;
      epoch_q.push_back(32'(t));
    end
    n_items = epoch_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < n_items) @(posedge clk);
    while (calendar_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
